>>> rtl/core/gdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdg_pkg
// Shared types, codes and constants of the Gaussian depth gridder.
// ----------------------------------------------------------------------------
package gdg_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int MAX_FEATURES_DEF    = 256;
  localparam int GRID_COLS_DEF       = 64;
  localparam int GRID_ROWS_DEF       = 48;
  localparam int EXP_TABLE_DEPTH_DEF = 512;

  // Half span of the query plane, 30.0 in Q8.8.
  localparam int HALF_SPAN = 7680;

  // Smoothed floor after reset, 85.0 in Q8.8.
  localparam logic [15:0] FLOOR_RESET = 16'd21760;

  // Register reset values.
  localparam logic [15:0] XY_LIMIT_RST     = 16'd7680;
  localparam logic [15:0] Z_MIN_RST        = 16'd2560;
  localparam logic [15:0] Z_MAX_RST        = 16'd51200;
  localparam logic [15:0] FLOOR_BAND_RST   = 16'd512;
  localparam logic [8:0]  MIN_NEARBY_RST   = 9'd10;
  localparam logic [23:0] WEIGHT_FLOOR_RST = 24'd6554;

  // Register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_XY_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_BAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NEARBY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FLOOR = 3'd5;

  // Request kinds.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NO_FLOOR = 2'd3;

  // Division by ten as a multiply by ceil(2^23/10) and a shift.
  localparam logic [19:0] RECIP10     = 20'd838861;
  localparam int          RECIP_SHIFT = 23;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_CLEAR,
    S_CF_I,
    S_CF_ZI,
    S_CF_J,
    S_CF_MUL,
    S_CF_UPD,
    S_Q_RUN,
    S_Q_CHK,
    S_Q_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic add;
    logic clear;
    logic cf_rd_i;
    logic cf_zi;
    logic cf_scan;
    logic cf_next;
    logic cf_mul;
    logic cf_upd;
    logic q_run;
    logic q_chk;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic skip;
    logic scan_end;
    logic q_end;
    logic use_floor;
    logic div_end;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/gaussian_depth_gridder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_depth_gridder
// Depth feature store with floor tracking and Gaussian kernel height queries.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result for
// each. An add request range-checks a feature and stores it if it passes and
// the store has room. A height query streams every held feature through an
// eight-stage kernel pipeline at one feature per cycle and then, unless it
// falls back to the floor, runs a sixteen-step shift-subtract divider. A
// close-frame request is the slow one: every feature that could beat the
// current best z triggers a full neighbor-count pass over the store through
// its single read port. A result cannot leave while the previous one still
// waits. The input side is ready whenever the sequencer is idle, even while
// the previous result still waits in the output register. Configuration
// writes are always ready and must only arrive while the block is idle.
module gaussian_depth_gridder #(
  parameter int MAX_FEATURES    = gdg_pkg::MAX_FEATURES_DEF,
  parameter int GRID_COLS       = gdg_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS       = gdg_pkg::GRID_ROWS_DEF,
  parameter int EXP_TABLE_DEPTH = gdg_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], grid_x[56:51], grid_z[62:57], pad[63]
  input  wire logic [63:0]                   in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                    in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // value[15:0], stored_count[24:16], zero pad[31:25]
  output logic [31:0]                        out_tdata,
  // accepted[0], from_floor[1], status[3:2]
  output logic [3:0]                         out_tuser,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gdg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [23:0]                   cfg_data
);

  gdg_pkg::cmd_t cmd;
  gdg_pkg::sts_t sts;

  logic [15:0] value;
  logic        accepted, from_floor;
  logic [8:0]  stored_count;
  logic [1:0]  status;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  gdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdg_dp #(
    .MAX_FEATURES    (MAX_FEATURES),
    .GRID_COLS       (GRID_COLS),
    .GRID_ROWS       (GRID_ROWS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_pos_x         (in_tdata[16:0]),
    .in_pos_y         (in_tdata[33:17]),
    .in_pos_z         (in_tdata[50:34]),
    .in_grid_x        (in_tdata[56:51]),
    .in_grid_z        (in_tdata[62:57]),
    .cfg_we           (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_value        (value),
    .out_accepted     (accepted),
    .out_from_floor   (from_floor),
    .out_stored_count (stored_count),
    .out_status       (status)
  );

  // The result fields come straight from the output register of the datapath.
  assign out_tdata = {7'd0, stored_count, value};
  assign out_tuser = {status, from_floor, accepted};

endmodule
`default_nettype wire

>>> rtl/core/gdg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdg_ctrl
// Sequencer of the gridder: accepts requests and steps the datapath.
// ----------------------------------------------------------------------------
module gdg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_req,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire gdg_pkg::sts_t sts,
  output gdg_pkg::cmd_t      cmd
);

  gdg_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      gdg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_req)
            gdg_pkg::REQ_ADD:   state_nxt = gdg_pkg::S_ADD;
            gdg_pkg::REQ_CLOSE: state_nxt = gdg_pkg::S_CF_I;
            gdg_pkg::REQ_QUERY: state_nxt = gdg_pkg::S_Q_RUN;
            gdg_pkg::REQ_CLEAR: state_nxt = gdg_pkg::S_CLEAR;
            default:            state_nxt = gdg_pkg::S_CLEAR;
          endcase
        end
      end
      gdg_pkg::S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = gdg_pkg::S_DONE;
      end
      gdg_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = gdg_pkg::S_DONE;
      end
      gdg_pkg::S_CF_I: begin
        if (sts.i_end) begin
          state_nxt = gdg_pkg::S_CF_MUL;
        end else begin
          cmd.cf_rd_i = 1'b1;
          state_nxt   = gdg_pkg::S_CF_ZI;
        end
      end
      gdg_pkg::S_CF_ZI: begin
        cmd.cf_zi = 1'b1;
        state_nxt = sts.skip ? gdg_pkg::S_CF_I : gdg_pkg::S_CF_J;
      end
      gdg_pkg::S_CF_J: begin
        if (sts.scan_end) begin
          cmd.cf_next = 1'b1;
          state_nxt   = gdg_pkg::S_CF_I;
        end else begin
          cmd.cf_scan = 1'b1;
        end
      end
      gdg_pkg::S_CF_MUL: begin
        cmd.cf_mul = 1'b1;
        state_nxt  = gdg_pkg::S_CF_UPD;
      end
      gdg_pkg::S_CF_UPD: begin
        cmd.cf_upd = 1'b1;
        state_nxt  = gdg_pkg::S_DONE;
      end
      gdg_pkg::S_Q_RUN: begin
        if (sts.q_end) begin
          state_nxt = gdg_pkg::S_Q_CHK;
        end else begin
          cmd.q_run = 1'b1;
        end
      end
      gdg_pkg::S_Q_CHK: begin
        cmd.q_chk = 1'b1;
        state_nxt = sts.use_floor ? gdg_pkg::S_DONE : gdg_pkg::S_Q_DIV;
      end
      gdg_pkg::S_Q_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_end) begin
          state_nxt = gdg_pkg::S_DONE;
        end
      end
      gdg_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = gdg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gdg_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/core/gdg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdg_dp
// Datapath of the gridder: feature store, floor search, kernel pipeline and
// the shift-subtract divider for the weighted mean.
// ----------------------------------------------------------------------------
module gdg_dp #(
  parameter int MAX_FEATURES    = gdg_pkg::MAX_FEATURES_DEF,
  parameter int GRID_COLS       = gdg_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS       = gdg_pkg::GRID_ROWS_DEF,
  parameter int EXP_TABLE_DEPTH = gdg_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gdg_pkg::cmd_t                 cmd,
  output gdg_pkg::sts_t                      sts,
  input  wire logic signed [16:0]            in_pos_x,
  input  wire logic signed [16:0]            in_pos_y,
  input  wire logic signed [16:0]            in_pos_z,
  input  wire logic [5:0]                    in_grid_x,
  input  wire logic [5:0]                    in_grid_z,
  input  wire logic                          cfg_we,
  input  wire logic [gdg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [23:0]                   cfg_data,
  output logic [15:0]                        out_value,
  output logic                               out_accepted,
  output logic                               out_from_floor,
  output logic [8:0]                         out_stored_count,
  output logic [1:0]                         out_status
);

  localparam int AW  = $clog2(MAX_FEATURES);
  localparam int CW  = $clog2(MAX_FEATURES + 1);
  localparam int NW  = (CW > 9) ? CW : 9;
  localparam int IW  = $clog2(EXP_TABLE_DEPTH);
  localparam int WSW = 17 + CW;
  localparam int ZSW = 33 + CW;
  localparam int DW  = ZSW + 1;
  localparam int CMPW = (WSW > 24) ? WSW : 24;

  typedef logic signed [16:0] gtab_t [64];
  typedef logic [16:0]        wtab_t [EXP_TABLE_DEPTH];

  function automatic gtab_t build_gx();
    gtab_t t;
    int    cc;
    for (int c = 0; c < 64; c++) begin
      cc   = (c > GRID_COLS - 1) ? GRID_COLS - 1 : c;
      t[c] = 17'((cc * 2 * gdg_pkg::HALF_SPAN) / GRID_COLS - gdg_pkg::HALF_SPAN);
    end
    return t;
  endfunction

  function automatic gtab_t build_gy();
    gtab_t t;
    int    cc;
    for (int c = 0; c < 64; c++) begin
      cc   = (c > GRID_ROWS - 1) ? GRID_ROWS - 1 : c;
      t[c] = 17'((cc * 2 * gdg_pkg::HALF_SPAN) / GRID_ROWS - gdg_pkg::HALF_SPAN);
    end
    return t;
  endfunction

  // exp(-16*i/DEPTH) in Q1.16: a Q0.32 power series for one step, then
  // repeated multiplication.
  function automatic wtab_t build_wtab();
    wtab_t       t;
    logic [63:0] one, s, sum, term, cur;
    one  = 64'd1 << 32;
    s    = (64'd16 << 32) / EXP_TABLE_DEPTH;
    sum  = one;
    term = one;
    cur  = one;
    for (int k = 1; k <= 12; k++) begin
      term = (term * s) >> 32;
      term = term / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      t[i] = 17'((cur + 64'h8000) >> 16);
      cur  = (cur * sum + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam gtab_t GXTAB = build_gx();
  localparam gtab_t GYTAB = build_gy();
  localparam wtab_t WTAB  = build_wtab();

  // Configuration registers.
  logic [15:0] xy_limit_r, z_min_r, z_max_r, floor_band_r;
  logic [8:0]  min_nearby_r;
  logic [23:0] weight_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_limit_r     <= gdg_pkg::XY_LIMIT_RST;
      z_min_r        <= gdg_pkg::Z_MIN_RST;
      z_max_r        <= gdg_pkg::Z_MAX_RST;
      floor_band_r   <= gdg_pkg::FLOOR_BAND_RST;
      min_nearby_r   <= gdg_pkg::MIN_NEARBY_RST;
      weight_floor_r <= gdg_pkg::WEIGHT_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gdg_pkg::REG_XY_LIMIT:     xy_limit_r     <= cfg_data[15:0];
        gdg_pkg::REG_Z_MIN:        z_min_r        <= cfg_data[15:0];
        gdg_pkg::REG_Z_MAX:        z_max_r        <= cfg_data[15:0];
        gdg_pkg::REG_FLOOR_BAND:   floor_band_r   <= cfg_data[15:0];
        gdg_pkg::REG_MIN_NEARBY:   min_nearby_r   <= cfg_data[8:0];
        gdg_pkg::REG_WEIGHT_FLOOR: weight_floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Feature store.
  logic signed [13:0] mem_x [MAX_FEATURES];
  logic signed [13:0] mem_y [MAX_FEATURES];
  logic [15:0]        mem_z [MAX_FEATURES];
  logic signed [13:0] rx_q, ry_q;
  logic [15:0]        rz_q;
  logic [AW-1:0]      rd_addr;

  logic [CW-1:0] count_r, i_r, j_r, n_r;
  logic [15:0]   floor_r, zi_r, best_r;
  logic          found_r, rv_r;
  logic signed [16:0] px_r, py_r, pz_r, gx_r, gy_r;
  logic [39:0]   prod_r;

  // Kernel pipeline.
  logic [5:0]         v_r;
  logic signed [16:0] dx_r, dy_r;
  logic [27:0]        sqx_r, sqy_r;
  logic [28:0]        d2_r;
  logic [IW-1:0]      idx_r;
  logic               inr_r;
  logic [16:0]        w_r, w6_r;
  logic [32:0]        zw_r;
  logic [15:0]        z1_r, z2_r, z3_r, z4_r, z5_r;
  logic [WSW-1:0]     wsum_r;
  logic [ZSW-1:0]     zsum_r;
  logic [DW-1:0]      rem_r;
  logic [3:0]         k_r;

  logic [15:0] res_value_r;
  logic        res_acc_r, res_ff_r;
  logic [1:0]  res_status_r;

  // Combinational helpers.
  logic signed [17:0] lim_p, lim_n, x18, y18, z18;
  logic               add_ok, full;
  logic signed [13:0] sat_x, sat_y;
  logic [15:0]        zdiff;
  logic               near;
  logic signed [33:0] sqx_full, sqy_full;
  logic [33:0]        idx_prod;
  logic [19:0]        fl_sum;
  logic [DW-1:0]      den_sh;
  logic [NW-1:0]      cnt_ext;

  assign lim_p  = {2'b00, xy_limit_r};
  assign lim_n  = -lim_p;
  assign x18    = 18'(px_r);
  assign y18    = 18'(py_r);
  assign z18    = 18'(pz_r);
  assign add_ok = (x18 < lim_p) && (x18 > lim_n) && (y18 < lim_p) && (y18 > lim_n) &&
                  (z18 < $signed({2'b00, z_max_r})) && (z18 > $signed({2'b00, z_min_r}));
  assign full   = (count_r >= CW'(MAX_FEATURES));
  assign sat_x  = (px_r > 17'sd8191) ? 14'sd8191 :
                  (px_r < -17'sd8192) ? -14'sd8192 : px_r[13:0];
  assign sat_y  = (py_r > 17'sd8191) ? 14'sd8191 :
                  (py_r < -17'sd8192) ? -14'sd8192 : py_r[13:0];
  assign zdiff  = (zi_r >= rz_q) ? zi_r - rz_q : rz_q - zi_r;
  assign near   = zdiff < floor_band_r;
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign idx_prod = 34'(d2_r[20:0]) * 34'(EXP_TABLE_DEPTH);
  assign fl_sum   = 20'({4'b0, floor_r} * 20'd9) + 20'(best_r) + 20'd5;
  assign den_sh   = DW'(wsum_r) << k_r;
  assign cnt_ext  = NW'(count_r);
  assign rd_addr  = cmd.cf_rd_i ? i_r[AW-1:0] : j_r[AW-1:0];

  assign sts.i_end     = (i_r == count_r);
  assign sts.skip      = found_r && (rz_q <= best_r);
  assign sts.scan_end  = (j_r == count_r) && !rv_r;
  assign sts.q_end     = (j_r == count_r) && !rv_r && (v_r == '0);
  assign sts.use_floor = (wsum_r == '0) || (CMPW'(wsum_r) < CMPW'(weight_floor_r));
  assign sts.div_end   = (k_r == 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.add && add_ok && !full) begin
      mem_x[count_r[AW-1:0]] <= sat_x;
      mem_y[count_r[AW-1:0]] <= sat_y;
      mem_z[count_r[AW-1:0]] <= pz_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    rx_q <= mem_x[rd_addr];
    ry_q <= mem_y[rd_addr];
    rz_q <= mem_z[rd_addr];
  end

  // Control state of the store and the floor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      floor_r <= gdg_pkg::FLOOR_RESET;
    end else begin
      if (cmd.add && add_ok && !full) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end
      if (cmd.cf_upd) begin
        floor_r <= prod_r[gdg_pkg::RECIP_SHIFT +: 16];
      end
    end
  end

  // Per-request work.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r         <= in_pos_x;
      py_r         <= in_pos_y;
      pz_r         <= in_pos_z;
      gx_r         <= GXTAB[in_grid_x];
      gy_r         <= GYTAB[in_grid_z];
      i_r          <= '0;
      j_r          <= '0;
      found_r      <= 1'b0;
      best_r       <= '0;
      rv_r         <= 1'b0;
      v_r          <= '0;
      wsum_r       <= '0;
      zsum_r       <= '0;
      res_value_r  <= '0;
      res_acc_r    <= 1'b0;
      res_ff_r     <= 1'b0;
      res_status_r <= gdg_pkg::STAT_OK;
    end

    if (cmd.add) begin
      if (!add_ok) begin
        res_status_r <= gdg_pkg::STAT_RANGE;
      end else if (full) begin
        res_status_r <= gdg_pkg::STAT_FULL;
      end else begin
        res_acc_r <= 1'b1;
      end
    end

    // Floor search: for each feature that could raise the best z, count its
    // neighbors in one pass over the store.
    if (cmd.cf_zi) begin
      zi_r <= rz_q;
      if (sts.skip) begin
        i_r <= i_r + 1'b1;
      end else begin
        j_r  <= '0;
        n_r  <= '0;
        rv_r <= 1'b0;
      end
    end
    if (cmd.cf_scan) begin
      if (j_r != count_r) begin
        j_r  <= j_r + 1'b1;
        rv_r <= 1'b1;
      end else begin
        rv_r <= 1'b0;
      end
      if (rv_r && near) begin
        n_r <= n_r + 1'b1;
      end
    end
    if (cmd.cf_next) begin
      if (NW'(n_r) >= NW'(min_nearby_r)) begin
        found_r <= 1'b1;
        best_r  <= zi_r;
      end
      i_r <= i_r + 1'b1;
    end
    if (cmd.cf_mul) begin
      prod_r <= 40'(fl_sum) * 40'(gdg_pkg::RECIP10);
    end
    if (cmd.cf_upd) begin
      res_value_r  <= prod_r[gdg_pkg::RECIP_SHIFT +: 16];
      res_status_r <= found_r ? gdg_pkg::STAT_OK : gdg_pkg::STAT_NO_FLOOR;
    end

    // Kernel pipeline: read, difference, square, sum, index, weight,
    // product, accumulate.
    if (cmd.q_run) begin
      if (j_r != count_r) begin
        j_r  <= j_r + 1'b1;
        rv_r <= 1'b1;
      end else begin
        rv_r <= 1'b0;
      end
      v_r   <= {v_r[4:0], rv_r};
      dx_r  <= gx_r - 17'(rx_q);
      dy_r  <= gy_r - 17'(ry_q);
      z1_r  <= rz_q;
      sqx_r <= sqx_full[27:0];
      sqy_r <= sqy_full[27:0];
      z2_r  <= z1_r;
      d2_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
      z3_r  <= z2_r;
      idx_r <= idx_prod[21 +: IW];
      inr_r <= (d2_r[28:21] == '0);
      z4_r  <= z3_r;
      w_r   <= inr_r ? WTAB[idx_r] : 17'd0;
      z5_r  <= z4_r;
      zw_r  <= 33'(z5_r) * 33'(w_r);
      w6_r  <= w_r;
      if (v_r[5]) begin
        wsum_r <= wsum_r + WSW'(w6_r);
        zsum_r <= zsum_r + ZSW'(zw_r);
      end
    end

    if (cmd.q_chk) begin
      if (sts.use_floor) begin
        res_value_r <= floor_r;
        res_ff_r    <= 1'b1;
      end else begin
        rem_r       <= DW'(zsum_r) + DW'(wsum_r >> 1);
        k_r         <= 4'd15;
        res_value_r <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_r >= den_sh) begin
        rem_r            <= rem_r - den_sh;
        res_value_r[k_r] <= 1'b1;
      end
      k_r <= k_r - 1'b1;
    end

    if (cmd.out_load) begin
      out_value        <= res_value_r;
      out_accepted     <= res_acc_r;
      out_from_floor   <= res_ff_r;
      out_stored_count <= cnt_ext[8:0];
      out_status       <= res_status_r;
    end
  end

endmodule
`default_nettype wire
